>>> rtl/dvmrp_pkg.sv
package dvmrp_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] source_net;
    logic [31:0] net_mask;
    logic [6:0]  route_metric;
    logic        default_route;
    logic        route_end;
    logic        message_end;
    logic        entry_valid;
    logic        truncated;
  } out_item_t;

  localparam logic [7:0] MASK_TOP    = 8'hFF;
  localparam logic [7:0] END_BIT     = 8'h80;
  localparam logic [7:0] METRIC_BITS = 8'h7F;

  // Nearest position above idx whose mask byte is nonzero; 4 when there is none.
  function automatic logic [2:0] next_pos(input logic [1:0] idx, input logic [23:0] mask);
    logic [2:0] pos;
    pos = 3'd4;
    for (int k = 3; k >= 1; k--) begin
      if ((3'(k) > {1'b0, idx}) && (mask[(3 - k) * 8 +: 8] != 8'd0)) begin
        pos = 3'(k);
      end
    end
    return pos;
  endfunction

endpackage

>>> rtl/dvmrp_parse.sv
module dvmrp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  dvmrp_pkg::in_item_t  in_item,
  output logic                 res_valid,
  output dvmrp_pkg::out_item_t res_item
);

  localparam logic [2:0] PH_MASK1  = 3'd0;
  localparam logic [2:0] PH_MASK2  = 3'd1;
  localparam logic [2:0] PH_MASK3  = 3'd2;
  localparam logic [2:0] PH_SRC0   = 3'd3;
  localparam logic [2:0] PH_SRCN   = 3'd4;
  localparam logic [2:0] PH_METRIC = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [23:0] mask_r, mask_nxt;
  logic [31:0] src_r, src_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [7:0]  b;
  logic        last;
  logic        end_bit;
  logic        dflt;
  logic        emit;
  logic [2:0]  pos;
  logic [1:0]  kc;
  logic [2:0]  after;

  assign b    = in_item.byte_value;
  assign last = in_item.last_byte;

  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    src_nxt   = src_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    res_item  = '0;
    end_bit   = (b & dvmrp_pkg::END_BIT) != 8'd0;
    dflt      = (mask_r == 24'd0) && (src_r[31:24] == 8'd0);
    pos       = dvmrp_pkg::next_pos(idx_r, mask_r);
    kc        = pos[2] ? 2'd3 : pos[1:0];
    after     = 3'd4;

    unique case (phase_r)
      PH_MASK2: begin
        mask_nxt  = mask_r | {8'd0, b, 8'd0};
        phase_nxt = PH_MASK3;
      end
      PH_MASK3: begin
        mask_nxt  = mask_r | {16'd0, b};
        phase_nxt = PH_SRC0;
      end
      PH_SRC0: begin
        src_nxt   = {b, 24'd0};
        idx_nxt   = 2'd0;
        after     = dvmrp_pkg::next_pos(2'd0, mask_r);
        phase_nxt = after[2] ? PH_METRIC : PH_SRCN;
      end
      PH_SRCN: begin
        // Place the byte at the next nonzero mask position.
        src_nxt   = src_r | (32'(b) << {~kc, 3'b000});
        idx_nxt   = kc;
        after     = dvmrp_pkg::next_pos(kc, mask_r);
        phase_nxt = after[2] ? PH_METRIC : PH_SRCN;
      end
      PH_METRIC: begin
        emit                   = 1'b1;
        res_item.source_net    = src_r;
        res_item.net_mask      = dflt ? 32'd0 : {dvmrp_pkg::MASK_TOP, mask_r};
        res_item.route_metric  = 7'(b & dvmrp_pkg::METRIC_BITS);
        res_item.default_route = dflt;
        res_item.route_end     = end_bit;
        res_item.message_end   = last;
        res_item.entry_valid   = 1'b1;
        res_item.truncated     = last && !end_bit;
        if (last || end_bit) begin
          phase_nxt = PH_MASK1;
          mask_nxt  = 24'd0;
        end else begin
          phase_nxt = PH_SRC0;
        end
        src_nxt = 32'd0;
        idx_nxt = 2'd0;
      end
      default: begin
        mask_nxt  = {b, 16'd0};
        src_nxt   = 32'd0;
        idx_nxt   = 2'd0;
        phase_nxt = PH_MASK2;
      end
    endcase

    // Message ended inside an entry: report what arrived and start over.
    if (last && (phase_r != PH_METRIC)) begin
      emit                 = 1'b1;
      res_item             = '0;
      res_item.source_net  = src_nxt;
      res_item.net_mask    = {dvmrp_pkg::MASK_TOP, mask_nxt};
      res_item.message_end = 1'b1;
      res_item.truncated   = 1'b1;
      phase_nxt            = PH_MASK1;
      mask_nxt             = 24'd0;
      src_nxt              = 32'd0;
      idx_nxt              = 2'd0;
    end
  end

  assign res_valid = in_acc && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MASK1;
      mask_r  <= 24'd0;
      src_r   <= 32'd0;
      idx_r   <= 2'd0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      src_r   <= src_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && last |=> phase_r == PH_MASK1 && mask_r == 24'd0 && src_r == 32'd0)
    else $error("state not cleared after last byte");

  a_partial_is_truncated: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_item.entry_valid |-> res_item.truncated && res_item.message_end)
    else $error("partial entry not marked truncated");

  a_index_phase: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> phase_r == PH_SRCN || phase_r == PH_METRIC)
    else $error("source index set outside source phase");

endmodule

>>> rtl/dvmrp_v3_route_report_decoder.sv
// Route report body decoder.
// The input channel (in_valid/in_stall/in_data) takes one body byte per
// transfer, with last_byte marking the final byte of a message. The result
// channel (out_valid/out_stall/out_data) carries one item per completed
// entry, or one truncated item when the message stops inside an entry.
// Throughput: one byte per cycle unless in_stall, no gaps between messages.
// A result is formed as the metric or last byte is transferred in and goes to
// the output register (the skid buffer on a stall); the per-byte phase update
// is one level of logic between the parser state and the output register.
// When the receiver stalls, the output register holds its result and a
// one-entry skid buffer absorbs the next result; in_stall rises only once
// the skid buffer is occupied, and falls the cycle after the held result
// is transferred out.
// Reset (rst_n low, synchronous) returns the parser to expect the first
// mask byte of a new route and empties both output stages.
module dvmrp_v3_route_report_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dvmrp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dvmrp_pkg::out_item_t out_data
);

  logic                 in_acc;
  logic                 res_valid;
  dvmrp_pkg::out_item_t res_item;

  logic                 out_valid_r;
  dvmrp_pkg::out_item_t out_data_r;
  logic                 skid_valid_r;
  dvmrp_pkg::out_item_t skid_data_r;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dvmrp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_data),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_item;
    end else if (res_valid) begin
      // hold the stalled result, park the new one
      skid_data_r <= res_item;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_stall |=> out_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output");

  a_stalled_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");

endmodule
